/* rtl/trdm_pkg.sv */
// ----------------------------------------------------------------------------
// trdm_pkg
// Shared types and constants of the transmit descriptor ring manager.
// ----------------------------------------------------------------------------
package trdm_pkg;

  localparam int unsigned SEG_W = 7;
  localparam int unsigned SUM_W = SEG_W + 1;

  localparam logic [2:0] CMD_SUBMIT = 3'd0;
  localparam logic [2:0] CMD_DONE   = 3'd1;
  localparam logic [2:0] CMD_RECLAIM = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_DRAIN  = 3'd4;

  localparam logic [7:0] THRESHOLD_RESET = 8'd5;
  localparam logic [7:0] STALL_MAX       = 8'd255;

  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_FREED   = 3'd3,
    KIND_DROPPED = 3'd4,
    KIND_RESET   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [SEG_W-1:0] seg_count;
    logic [15:0]      packet_tag;
    logic [5:0]       done_index;
    logic [5:0]       hw_head;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] tag_out;
    logic [5:0]  first_slot;
    logic [5:0]  last_slot;
    logic [5:0]  outstanding;
    logic [5:0]  tail_out;
    logic        last_flag;
  } out_item_t;

  typedef struct packed {
    logic  ld_in;
    logic  emit;
    kind_e kind;
    logic  finish;
    logic  free_slot;
    logic  drop_slot;
    logic  drop_start;
    logic  restart;
    logic  claim;
    logic  mark_done;
    logic  watch_upd;
    logic  watch_clr;
  } cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic       segs_zero;
    logic       used_zero;
    logic       head_done;
    logic       head_ends;
    logic       full;
    logic       trip;
    logic       emit_ok;
    logic       flush_ok;
  } sts_t;

endpackage

/* rtl/trdm_ctrl.sv */
// ----------------------------------------------------------------------------
// trdm_ctrl
// Sequencer of the ring manager: decodes a command and walks the ring.
// ----------------------------------------------------------------------------
module trdm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  trdm_pkg::sts_t sts_i,
  output trdm_pkg::cmd_t cmd_o
);
  import trdm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_R_WAIT, S_R_EVAL, S_SUB_CHK, S_W_UPD, S_W_CHK,
    S_D_START, S_D_WAIT, S_D_EVAL, S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.kind = KIND_ACCEPT;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.command)
          CMD_SUBMIT: begin
            if (sts_i.segs_zero) begin
              if (sts_i.emit_ok) begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = KIND_EMPTY;
                state_d = S_FINISH;
              end
            end else begin
              state_d = S_R_WAIT;
            end
          end
          CMD_DONE: begin
            cmd_o.mark_done = 1'b1;
            state_d = S_FINISH;
          end
          CMD_RECLAIM, CMD_TICK: state_d = S_R_WAIT;
          CMD_DRAIN: state_d = S_D_START;
          default: state_d = S_FINISH;
        endcase
      end
      S_R_WAIT: state_d = S_R_EVAL;
      S_R_EVAL: begin
        if (!sts_i.used_zero && sts_i.head_done) begin
          if (!sts_i.head_ends || sts_i.emit_ok) begin
            cmd_o.free_slot = 1'b1;
            cmd_o.emit = sts_i.head_ends;
            cmd_o.kind = KIND_FREED;
            state_d = S_R_WAIT;
          end
        end else begin
          case (sts_i.command)
            CMD_SUBMIT: state_d = S_SUB_CHK;
            CMD_TICK:   state_d = S_W_UPD;
            default:    state_d = S_FINISH;
          endcase
        end
      end
      S_SUB_CHK: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.full) begin
            cmd_o.kind = KIND_FULL;
          end else begin
            cmd_o.kind  = KIND_ACCEPT;
            cmd_o.claim = 1'b1;
          end
          state_d = S_FINISH;
        end
      end
      S_W_UPD: begin
        if (sts_i.used_zero) begin
          cmd_o.watch_clr = 1'b1;
          state_d = S_FINISH;
        end else begin
          cmd_o.watch_upd = 1'b1;
          state_d = S_W_CHK;
        end
      end
      S_W_CHK: begin
        if (sts_i.trip) begin
          cmd_o.watch_clr = 1'b1;
          state_d = S_D_START;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_D_START: begin
        cmd_o.drop_start = 1'b1;
        state_d = S_D_WAIT;
      end
      S_D_WAIT: state_d = S_D_EVAL;
      S_D_EVAL: begin
        if (!sts_i.used_zero) begin
          if (!sts_i.head_ends || sts_i.emit_ok) begin
            cmd_o.drop_slot = 1'b1;
            cmd_o.emit = sts_i.head_ends;
            cmd_o.kind = KIND_DROPPED;
            state_d = S_D_WAIT;
          end
        end else if (sts_i.emit_ok) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = KIND_RESET;
          cmd_o.restart = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.flush_ok) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/trdm_dp.sv */
// ----------------------------------------------------------------------------
// trdm_dp
// Ring state, tag memory, watchdog counters and the result staging registers.
// ----------------------------------------------------------------------------
module trdm_dp #(
  parameter int unsigned RING_SLOTS = 64,
  parameter int unsigned TAG_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trdm_pkg::in_item_t  in_data_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  trdm_pkg::cmd_t      cmd_i,
  output trdm_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trdm_pkg::out_item_t out_data_o
);
  import trdm_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_SLOTS);
  localparam int unsigned CNT_W = $clog2(RING_SLOTS + 1);
  localparam int unsigned TW    = (TAG_BITS < 16) ? TAG_BITS : 16;

  in_item_t                in_q;
  logic [RING_SLOTS-1:0]   done_q, ends_q;
  logic [IDX_W-1:0]        head_q, tail_q;
  logic [CNT_W-1:0]        used_q, drop_cnt_q;
  logic [5:0]              prev_hw_q;
  logic [7:0]              stall_q, thr_q;
  logic [TW-1:0]           tag_mem [RING_SLOTS];
  logic [TW-1:0]           rdata_q;
  out_item_t               pend_q, out_q;
  logic                    pend_v_q, out_v_q;

  logic [SUM_W-1:0]        tail_sum, used_sum;
  logic [IDX_W-1:0]        tail_nx, last_slot, head_nx;
  logic [RING_SLOTS-1:0]   claim_mask;
  logic [TW-1:0]           in_tag;
  logic                    emit_ok, flush_ok;
  out_item_t               res;

  assign in_tag   = in_q.packet_tag[TW-1:0];
  assign tail_sum = SUM_W'(tail_q) + SUM_W'(in_q.seg_count);
  assign used_sum = SUM_W'(used_q) + SUM_W'(in_q.seg_count);
  assign tail_nx  = (tail_sum >= SUM_W'(RING_SLOTS)) ? IDX_W'(tail_sum - SUM_W'(RING_SLOTS))
                                                      : IDX_W'(tail_sum);
  assign last_slot = (tail_nx == '0) ? IDX_W'(RING_SLOTS - 1) : tail_nx - 1'b1;
  assign head_nx   = (head_q == IDX_W'(RING_SLOTS - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    int off;
    for (int j = 0; j < RING_SLOTS; j++) begin
      off = (j >= int'(tail_q)) ? j - int'(tail_q) : j + int'(RING_SLOTS) - int'(tail_q);
      claim_mask[j] = (off < int'(in_q.seg_count));
    end
  end

  assign emit_ok  = !pend_v_q || !out_v_q || out_ready_i;
  assign flush_ok = !out_v_q || out_ready_i;

  always_comb begin
    sts_o.command   = in_q.command;
    sts_o.segs_zero = (in_q.seg_count == '0);
    sts_o.used_zero = (used_q == '0);
    sts_o.head_done = done_q[head_q];
    sts_o.head_ends = ends_q[head_q];
    sts_o.full      = (used_sum > SUM_W'(RING_SLOTS - 1));
    sts_o.trip      = (stall_q >= thr_q);
    sts_o.emit_ok   = emit_ok;
    sts_o.flush_ok  = flush_ok;
  end

  always_comb begin
    res = '0;
    res.kind = cmd_i.kind;
    case (cmd_i.kind)
      KIND_ACCEPT: begin
        res.tag_out     = 16'(in_tag);
        res.first_slot  = 6'(tail_q);
        res.last_slot   = 6'(last_slot);
        res.outstanding = 6'(used_sum);
        res.tail_out    = 6'(tail_nx);
      end
      KIND_EMPTY, KIND_FULL: begin
        res.tag_out     = 16'(in_tag);
        res.outstanding = 6'(used_q);
        res.tail_out    = 6'(tail_q);
      end
      KIND_FREED: begin
        res.tag_out     = 16'(rdata_q);
        res.last_slot   = 6'(head_q);
        res.outstanding = 6'(used_q - 1'b1);
        res.tail_out    = 6'(tail_q);
      end
      KIND_DROPPED: begin
        res.tag_out     = 16'(rdata_q);
        res.last_slot   = 6'(head_q);
        res.outstanding = 6'(used_q - 1'b1);
      end
      KIND_RESET: res.outstanding = 6'(drop_cnt_q);
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.drop_start) begin
      drop_cnt_q <= used_q;
    end
    if (cmd_i.claim) begin
      tag_mem[last_slot] <= in_tag;
    end
    rdata_q <= tag_mem[head_q];
    if (cmd_i.emit) begin
      pend_q <= res;
      if (pend_v_q) begin
        out_q <= pend_q;
      end
    end else if (cmd_i.finish && pend_v_q) begin
      out_q <= {pend_q[$bits(out_item_t)-1:1], 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      ends_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      used_q    <= '0;
      prev_hw_q <= '0;
      stall_q   <= '0;
      thr_q     <= THRESHOLD_RESET;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.mark_done && ({1'b0, in_q.done_index} < 7'(RING_SLOTS))) begin
        done_q[in_q.done_index[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd_i.free_slot) begin
        done_q[head_q] <= 1'b0;
        ends_q[head_q] <= 1'b0;
        head_q <= head_nx;
        used_q <= used_q - 1'b1;
      end
      if (cmd_i.drop_slot) begin
        ends_q[head_q] <= 1'b0;
        head_q <= head_nx;
        used_q <= used_q - 1'b1;
      end
      if (cmd_i.restart) begin
        done_q <= '0;
        ends_q <= '0;
        head_q <= '0;
        tail_q <= '0;
      end
      if (cmd_i.claim) begin
        done_q <= done_q & ~claim_mask;
        ends_q <= (ends_q & ~claim_mask) | (RING_SLOTS'(1) << last_slot);
        tail_q <= tail_nx;
        used_q <= CNT_W'(used_sum);
      end
      if (cmd_i.watch_upd) begin
        if (in_q.hw_head == prev_hw_q) begin
          if (stall_q != STALL_MAX) begin
            stall_q <= stall_q + 1'b1;
          end
        end else begin
          stall_q <= '0;
        end
        prev_hw_q <= in_q.hw_head;
      end
      if (cmd_i.watch_clr) begin
        stall_q <= '0;
      end
      if (cmd_i.emit) begin
        pend_v_q <= 1'b1;
        out_v_q  <= pend_v_q || (out_v_q && !out_ready_i);
      end else if (cmd_i.finish && pend_v_q) begin
        pend_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q < CNT_W'(RING_SLOTS)) else $error("ring use count out of range");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q == '0) == (head_q == tail_q)) else $error("ring pointers disagree with count");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && pend_v_q && out_v_q |-> out_ready_i) else $error("result staging overrun");
  a_claim_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.claim |-> !sts_o.full && !sts_o.segs_zero) else $error("claim on refused chain");

endmodule

/* rtl/tx_descriptor_ring_manager_unit.sv */
// ----------------------------------------------------------------------------
// tx_descriptor_ring_manager_unit
// Transmit descriptor ring bookkeeping with a hang watchdog.
// ----------------------------------------------------------------------------
// One item is taken at a time. A descriptor-done or unknown command goes
// straight from decode to finish; an empty submit also waits for room in the
// result stage. Reclaim, submit and watchdog tick walk the ring from the head,
// with a wait state per freed slot for the registered tag memory read, then a
// final check; a submit then takes its accept or full decision and a tick
// updates and checks the watchdog. Drain and a watchdog ring reset pass a start
// state and walk every outstanding slot with the same wait state per slot, then
// emit the ring reset result. Results leave through a two-entry stage,
// so the next item is taken while the last result still waits.
module tx_descriptor_ring_manager_unit #(
  parameter int unsigned RING_SLOTS = 64,
  parameter int unsigned TAG_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  trdm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trdm_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import trdm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trdm_dp #(
    .RING_SLOTS (RING_SLOTS),
    .TAG_BITS   (TAG_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the transmit descriptor ring manager against a behavioral ring
// model: directed corner items, then random submit, done-mark, reclaim,
// watchdog and drain traffic under several hang thresholds, with random
// gaps and stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import trdm_pkg::*;

  localparam int SLOTS = 64;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  tx_descriptor_ring_manager_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ring model state
  logic slot_done[SLOTS];
  logic slot_ends[SLOTS];
  logic [15:0] slot_tag[SLOTS];
  int ring_head, ring_tail, used_slots, prev_hw_head, stall_ticks;
  logic [7:0] hang_threshold;

  in_item_t pending_items[$];
  out_item_t expected_events[$];
  int errors = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int hold_left = 0;
  bit long_hold_done = 0;

  task automatic push_event(kind_e k, logic [15:0] tag, int first, int last, int outs,
                            int tail);
    out_item_t e;
    e.kind = k;
    e.tag_out = tag;
    e.first_slot = first[5:0];
    e.last_slot = last[5:0];
    e.outstanding = outs[5:0];
    e.tail_out = tail[5:0];
    e.last_flag = 1'b0;
    expected_events.push_back(e);
  endtask

  task automatic reclaim_done();
    int i;
    while (used_slots > 0 && slot_done[ring_head]) begin
      i = ring_head;
      slot_done[i] = 1'b0;
      ring_head = (i + 1) % SLOTS;
      used_slots--;
      if (slot_ends[i]) begin
        slot_ends[i] = 1'b0;
        push_event(KIND_FREED, slot_tag[i], 0, i, used_slots, ring_tail);
      end
    end
  endtask

  task automatic drop_ring();
    int i;
    int dropped;
    dropped = used_slots;
    while (used_slots > 0) begin
      i = ring_head;
      ring_head = (i + 1) % SLOTS;
      used_slots--;
      if (slot_ends[i]) push_event(KIND_DROPPED, slot_tag[i], 0, i, used_slots, 0);
    end
    for (int s = 0; s < SLOTS; s++) begin
      slot_done[s] = 1'b0;
      slot_ends[s] = 1'b0;
    end
    ring_head = 0;
    ring_tail = 0;
    push_event(KIND_RESET, '0, 0, 0, dropped, 0);
  endtask

  task automatic predict_ring(in_item_t it);
    int ev_start;
    int segs;
    int i;
    int last;
    ev_start = expected_events.size();
    segs = int'(it.seg_count);
    case (it.command)
      CMD_SUBMIT: begin
        if (segs == 0) begin
          push_event(KIND_EMPTY, it.packet_tag, 0, 0, used_slots, ring_tail);
        end else begin
          reclaim_done();
          if (used_slots + segs > SLOTS - 1) begin
            push_event(KIND_FULL, it.packet_tag, 0, 0, used_slots, ring_tail);
          end else begin
            i = ring_tail;
            last = i;
            for (int k = 0; k < segs; k++) begin
              slot_done[i] = 1'b0;
              slot_ends[i] = 1'b0;
              last = i;
              i = (i + 1) % SLOTS;
            end
            slot_ends[last] = 1'b1;
            slot_tag[last] = it.packet_tag;
            used_slots += segs;
            push_event(KIND_ACCEPT, it.packet_tag, ring_tail, last, used_slots, i);
            ring_tail = i;
          end
        end
      end
      CMD_DONE: slot_done[it.done_index] = 1'b1;
      CMD_RECLAIM: reclaim_done();
      CMD_TICK: begin
        reclaim_done();
        if (used_slots > 0) begin
          if (int'(it.hw_head) == prev_hw_head) begin
            if (stall_ticks < 255) stall_ticks++;
          end else begin
            stall_ticks = 0;
          end
          prev_hw_head = int'(it.hw_head);
          if (stall_ticks >= int'(hang_threshold)) begin
            drop_ring();
            stall_ticks = 0;
          end
        end else begin
          stall_ticks = 0;
        end
      end
      CMD_DRAIN: drop_ring();
      default: ;
    endcase
    if (expected_events.size() > ev_start)
      expected_events[expected_events.size() - 1].last_flag = 1'b1;
  endtask

  task automatic send_item(logic [2:0] cmd, int segs, logic [15:0] tag, int done_idx,
                           int hw);
    in_item_t it;
    it.command = cmd;
    it.seg_count = segs[6:0];
    it.packet_tag = tag;
    it.done_index = done_idx[5:0];
    it.hw_head = hw[5:0];
    predict_ring(it);
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid_i || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [7:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hang_threshold = value;
  endtask

  task automatic random_phase(int count);
    int n;
    int pick;
    int segs;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(19) == 0) segs = 0;
        else if ($urandom_range(9) == 0) segs = $urandom_range(64, 1);
        else segs = $urandom_range(8, 1);
        send_item(CMD_SUBMIT, segs, 16'($urandom), $urandom_range(63), $urandom_range(63));
      end else if (pick < 65) begin
        if (used_slots > 0 && $urandom_range(9) != 0)
          send_item(CMD_DONE, $urandom_range(127), 16'($urandom),
                    (ring_head + $urandom_range(used_slots < 4 ? used_slots - 1 : 3)) % SLOTS,
                    $urandom_range(63));
        else
          send_item(CMD_DONE, $urandom_range(127), 16'($urandom), $urandom_range(63),
                    $urandom_range(63));
      end else if (pick < 80) begin
        send_item(CMD_RECLAIM, $urandom_range(127), 16'($urandom), $urandom_range(63),
                  $urandom_range(63));
      end else if (pick < 93) begin
        send_item(CMD_TICK, $urandom_range(127), 16'($urandom), $urandom_range(63),
                  ($urandom_range(3) != 0) ? prev_hw_head : $urandom_range(63));
      end else if (pick < 96) begin
        send_item(CMD_DRAIN, $urandom_range(127), 16'($urandom), $urandom_range(63),
                  $urandom_range(63));
      end else begin
        send_item(3'($urandom_range(7, 5)), $urandom_range(127), 16'($urandom),
                  $urandom_range(63), $urandom_range(63));
        n--;
      end
      n++;
      if (pending_items.size() > 16) @(posedge clk_i);
    end
  endtask

  // sender
  always @(posedge clk_i) begin
    logic keep;
    keep = in_valid_i && !in_ready_o;
    if (in_valid_i && in_ready_o) begin
      void'(pending_items.pop_front());
      send_gap <= ($urandom_range(9) == 0) ? $urandom_range(30, 5) :
                  (($urandom_range(2) == 0) ? $urandom_range(2) : 0);
    end
    if (!keep) begin
      if (send_gap > 0 && !(in_valid_i && in_ready_o)) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!(in_valid_i && in_ready_o) && pending_items.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off
  always @(posedge clk_i) begin
    if (!long_hold_done && rst_ni && pending_items.size() > 8) begin
      long_hold_done <= 1'b1;
      hold_left <= 600;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(3) == 0) begin
      hold_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t exp_ev;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %p", $time, out_data_o);
      end else begin
        exp_ev = expected_events.pop_front();
        if (out_data_o !== exp_ev) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp_ev, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_done[s] = 1'b0;
      slot_ends[s] = 1'b0;
      slot_tag[s] = '0;
    end
    ring_head = 0;
    ring_tail = 0;
    used_slots = 0;
    prev_hw_head = 0;
    stall_ticks = 0;
    hang_threshold = THRESHOLD_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_item(CMD_SUBMIT, 0, 16'hFFFF, 0, 0);
    send_item(CMD_TICK, 0, 0, 0, 63);
    send_item(CMD_DRAIN, 0, 0, 0, 0);
    send_item(CMD_DONE, 0, 0, 5, 0);
    send_item(CMD_SUBMIT, 63, 16'hA5A5, 63, 0);
    send_item(CMD_SUBMIT, 1, 16'h0001, 0, 0);
    for (int k = 0; k < 6; k++) send_item(CMD_TICK, 0, 0, 0, 0);
    send_item(CMD_SUBMIT, 64, 16'h8000, 0, 0);
    send_item(CMD_SUBMIT, 2, 16'h1234, 0, 0);
    send_item(CMD_SUBMIT, 3, 16'h5678, 0, 0);
    for (int k = 0; k < 5; k++) send_item(CMD_DONE, 0, 0, k, 0);
    send_item(CMD_RECLAIM, 127, 16'hFFFF, 63, 63);
    send_item(3'd5, 127, 16'hFFFF, 63, 63);
    send_item(3'd7, 0, 0, 0, 0);
    send_item(CMD_DRAIN, 0, 0, 0, 0);

    write_threshold(8'd1);
    random_phase(50);
    write_threshold(8'd255);
    random_phase(45);
    write_threshold(8'd0);
    random_phase(45);
    write_threshold(8'($urandom_range(254, 1)));
    random_phase(45);
    write_threshold(THRESHOLD_RESET);
    random_phase(45);

    while (pending_items.size() > 0 || in_valid_i || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
